@@ rtl/core/rarh_pkg.sv @@
// ----------------------------------------------------------------------------
// rarh_pkg
// Types and constants shared by the ray versus rectangle hit core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rarh_pkg;

  localparam int COORD_WIDTH    = 32;
  localparam int FRAC_BITS      = 16;
  localparam int TEX_BITS       = 16;
  localparam int T_WIDTH        = 31;
  localparam int TEX_WIDTH      = TEX_BITS + 1;
  localparam int MAT_WIDTH      = 8;
  localparam int AXIS_WIDTH     = 2;
  localparam int CFG_IDX_WIDTH  = 3;
  localparam int CFG_DATA_WIDTH = 32;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_AW       = 2;

  localparam logic [AXIS_WIDTH-1:0] AXIS_XY = 2'd0;
  localparam logic [AXIS_WIDTH-1:0] AXIS_XZ = 2'd1;
  localparam logic [AXIS_WIDTH-1:0] AXIS_YZ = 2'd2;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_PLANE_AXIS   = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_PLANE_OFFSET = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_A_LOW        = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_A_HIGH       = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_B_LOW        = 3'd4;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_B_HIGH       = 3'd5;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_MATERIAL_ID  = 3'd6;

  localparam logic signed [COORD_WIDTH-1:0] COORD_ONE = 32'sh0001_0000;

  typedef logic [2:0][COORD_WIDTH-1:0] coord_vec_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] origin_x;
    logic signed [COORD_WIDTH-1:0] origin_y;
    logic signed [COORD_WIDTH-1:0] origin_z;
    logic signed [COORD_WIDTH-1:0] dir_x;
    logic signed [COORD_WIDTH-1:0] dir_y;
    logic signed [COORD_WIDTH-1:0] dir_z;
    logic [T_WIDTH-1:0]            t_lower;
    logic [T_WIDTH-1:0]            t_upper;
  } ray_t;

  typedef struct packed {
    logic                          hit;
    logic [T_WIDTH-1:0]            hit_t;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic                          front_face;
    logic [TEX_WIDTH-1:0]          tex_u;
    logic [TEX_WIDTH-1:0]          tex_v;
    logic [MAT_WIDTH-1:0]          hit_material;
  } res_t;

  typedef struct packed {
    logic [CFG_IDX_WIDTH-1:0]  index;
    logic [CFG_DATA_WIDTH-1:0] value;
  } cfg_wr_t;

  typedef struct packed {
    logic [AXIS_WIDTH-1:0]         plane_axis;
    logic signed [COORD_WIDTH-1:0] plane_offset;
    logic signed [COORD_WIDTH-1:0] a_low;
    logic signed [COORD_WIDTH-1:0] a_high;
    logic signed [COORD_WIDTH-1:0] b_low;
    logic signed [COORD_WIDTH-1:0] b_high;
    logic [MAT_WIDTH-1:0]          material_id;
  } cfg_t;

  typedef struct packed {
    coord_vec_t             org;
    coord_vec_t             dir;
    logic [T_WIDTH-1:0]     t_lower;
    logic [T_WIDTH-1:0]     t_upper;
    logic [COORD_WIDTH-1:0] mag_num;
    logic [COORD_WIDTH-1:0] mag_den;
    logic                   neg_dn;
    logic                   miss;
  } job_t;

endpackage

@@ rtl/core/rarh_chan_if.sv @@
// ----------------------------------------------------------------------------
// rarh_chan_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rarh_chan_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/rarh_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// rarh_cfg_regs
// Rectangle configuration registers written over the configuration channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rarh_cfg_regs (
  input  logic            clk,
  input  logic            rst_n,
  rarh_chan_if.sink       cfg_ch,
  output rarh_pkg::cfg_t  cfg
);
  import rarh_pkg::*;

  cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.plane_axis   <= AXIS_XY;
      cfg_r.plane_offset <= '0;
      cfg_r.a_low        <= '0;
      cfg_r.a_high       <= COORD_ONE;
      cfg_r.b_low        <= '0;
      cfg_r.b_high       <= COORD_ONE;
      cfg_r.material_id  <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.data.index)
        CFG_PLANE_AXIS:   cfg_r.plane_axis   <= cfg_ch.data.value[AXIS_WIDTH-1:0];
        CFG_PLANE_OFFSET: cfg_r.plane_offset <= cfg_ch.data.value[COORD_WIDTH-1:0];
        CFG_A_LOW:        cfg_r.a_low        <= cfg_ch.data.value[COORD_WIDTH-1:0];
        CFG_A_HIGH:       cfg_r.a_high       <= cfg_ch.data.value[COORD_WIDTH-1:0];
        CFG_B_LOW:        cfg_r.b_low        <= cfg_ch.data.value[COORD_WIDTH-1:0];
        CFG_B_HIGH:       cfg_r.b_high       <= cfg_ch.data.value[COORD_WIDTH-1:0];
        CFG_MATERIAL_ID:  cfg_r.material_id  <= cfg_ch.data.value[MAT_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

@@ rtl/core/rarh_front.sv @@
// ----------------------------------------------------------------------------
// rarh_front
// Accepts rays, picks the normal axis and classifies early misses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rarh_front (
  rarh_chan_if.sink       in_ch,
  input  rarh_pkg::cfg_t  cfg,
  input  logic            push_ready,
  output logic            push_valid,
  output rarh_pkg::job_t  push_data
);
  import rarh_pkg::*;

  logic                          axis_bad;
  logic signed [COORD_WIDTH-1:0] org_n;
  logic signed [COORD_WIDTH-1:0] dir_n;
  logic signed [COORD_WIDTH:0]   num;
  logic [COORD_WIDTH:0]          num_abs;

  assign push_valid  = in_ch.valid;
  assign in_ch.ready = push_ready;

  always_comb begin
    axis_bad = 1'b0;
    org_n    = in_ch.data.origin_z;
    dir_n    = in_ch.data.dir_z;
    case (cfg.plane_axis)
      AXIS_XY: begin
        org_n = in_ch.data.origin_z;
        dir_n = in_ch.data.dir_z;
      end
      AXIS_XZ: begin
        org_n = in_ch.data.origin_y;
        dir_n = in_ch.data.dir_y;
      end
      AXIS_YZ: begin
        org_n = in_ch.data.origin_x;
        dir_n = in_ch.data.dir_x;
      end
      default: axis_bad = 1'b1;
    endcase
  end

  assign num     = {cfg.plane_offset[COORD_WIDTH-1], cfg.plane_offset}
                 - {org_n[COORD_WIDTH-1], org_n};
  assign num_abs = num[COORD_WIDTH] ? -num : num;

  always_comb begin
    push_data.org     = {in_ch.data.origin_z, in_ch.data.origin_y, in_ch.data.origin_x};
    push_data.dir     = {in_ch.data.dir_z, in_ch.data.dir_y, in_ch.data.dir_x};
    push_data.t_lower = in_ch.data.t_lower;
    push_data.t_upper = in_ch.data.t_upper;
    push_data.mag_num = num_abs[COORD_WIDTH-1:0];
    push_data.mag_den = dir_n[COORD_WIDTH-1] ? -dir_n : dir_n;
    push_data.neg_dn  = dir_n[COORD_WIDTH-1];
    push_data.miss    = axis_bad || (dir_n == '0)
                     || ((num != '0) && (num[COORD_WIDTH] != dir_n[COORD_WIDTH-1]));
  end

endmodule

@@ rtl/core/rarh_queue.sv @@
// ----------------------------------------------------------------------------
// rarh_queue
// Short queue between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rarh_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  rarh_pkg::job_t  push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output rarh_pkg::job_t  pop_data
);
  import rarh_pkg::*;

  job_t                mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r;
  logic [QUEUE_AW-1:0] rd_ptr_r;
  logic [QUEUE_AW:0]   count_r;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (count_r != (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop) count_r <= count_r + 1'b1;
      else if (!do_push && do_pop) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

@@ rtl/core/rarh_back.sv @@
// ----------------------------------------------------------------------------
// rarh_back
// Pipelined distance divide, hit point, bounds check and texture divide.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rarh_back (
  input  logic            clk,
  input  logic            rst_n,
  input  rarh_pkg::cfg_t  cfg,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  rarh_pkg::job_t  pop_data,
  rarh_chan_if.source     out_ch
);
  import rarh_pkg::*;

  localparam int DIV_STEPS = T_WIDTH;
  localparam int DIV_SHIFT = T_WIDTH - FRAC_BITS;
  localparam int TEX_STEPS = TEX_WIDTH;
  localparam int PROD_W    = COORD_WIDTH + T_WIDTH;
  localparam int PT_W      = COORD_WIDTH + FRAC_BITS;

  typedef struct packed {
    coord_vec_t             org;
    coord_vec_t             dir;
    logic [T_WIDTH-1:0]     t_lower;
    logic [T_WIDTH-1:0]     t_upper;
    logic                   neg_dn;
    logic                   miss;
    logic [COORD_WIDTH-1:0] rem;
    logic [COORD_WIDTH-1:0] den;
    logic [T_WIDTH-1:0]     dvd;
    logic [T_WIDTH-1:0]     quo;
  } dv_t;

  typedef struct packed {
    coord_vec_t                 org;
    logic [2:0][PROD_W-1:0]     prod;
    logic [T_WIDTH-1:0]         t;
    logic                       neg_dn;
    logic                       miss;
  } ml_t;

  typedef struct packed {
    logic [2:0][PT_W-1:0] pt;
    logic [T_WIDTH-1:0]   t;
    logic                 neg_dn;
    logic                 miss;
  } pt_t;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] rem;
    logic [COORD_WIDTH-1:0] den;
    logic [TEX_WIDTH-1:0]   dvd;
    logic [TEX_WIDTH-1:0]   quo;
    logic                   zspan;
  } ln_t;

  typedef struct packed {
    coord_vec_t         pt;
    logic [T_WIDTH-1:0] t;
    logic               neg_dn;
    logic               miss;
    logic [1:0]         unused_pad;
    ln_t                lane_a;
    ln_t                lane_b;
  } tx_t;

  function automatic dv_t div_step(dv_t s);
    dv_t                  r;
    logic [COORD_WIDTH:0] part;
    logic                 ge;
    r     = s;
    part  = {s.rem, s.dvd[T_WIDTH-1]};
    ge    = (part >= {1'b0, s.den});
    part  = ge ? (part - {1'b0, s.den}) : part;
    r.rem = part[COORD_WIDTH-1:0];
    r.quo = {s.quo[T_WIDTH-2:0], ge};
    r.dvd = {s.dvd[T_WIDTH-2:0], 1'b0};
    return r;
  endfunction

  function automatic ln_t tex_step(ln_t s);
    ln_t                  r;
    logic [COORD_WIDTH:0] part;
    logic                 ge;
    r     = s;
    part  = {s.rem, s.dvd[TEX_WIDTH-1]};
    ge    = (part >= {1'b0, s.den});
    part  = ge ? (part - {1'b0, s.den}) : part;
    r.rem = part[COORD_WIDTH-1:0];
    r.quo = {s.quo[TEX_WIDTH-2:0], ge};
    r.dvd = {s.dvd[TEX_WIDTH-2:0], 1'b0};
    return r;
  endfunction

  function automatic tx_t tx_step(tx_t s);
    tx_t r;
    r        = s;
    r.lane_a = tex_step(s.lane_a);
    r.lane_b = tex_step(s.lane_b);
    return r;
  endfunction

  function automatic ln_t tex_init(logic signed [PT_W-1:0] c,
                                   logic signed [COORD_WIDTH-1:0] lo,
                                   logic signed [COORD_WIDTH-1:0] hi);
    ln_t                      r;
    logic signed [PT_W-1:0]   off;
    logic [COORD_WIDTH:0]     span;
    off     = c - {{(PT_W - COORD_WIDTH){lo[COORD_WIDTH-1]}}, lo};
    span    = {hi[COORD_WIDTH-1], hi} - {lo[COORD_WIDTH-1], lo};
    r.rem   = {1'b0, off[COORD_WIDTH-1:1]};
    r.dvd   = {off[0], {TEX_BITS{1'b0}}};
    r.den   = span[COORD_WIDTH-1:0];
    r.quo   = '0;
    r.zspan = (span == '0);
    return r;
  endfunction

  function automatic logic [COORD_WIDTH-1:0] sat_coord(logic signed [PT_W-1:0] v);
    logic [COORD_WIDTH-1:0] r;
    if (v[PT_W-1:COORD_WIDTH-1] == '0 || v[PT_W-1:COORD_WIDTH-1] == '1) begin
      r = v[COORD_WIDTH-1:0];
    end else if (v[PT_W-1]) begin
      r = {1'b1, {(COORD_WIDTH - 1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic in_range(logic signed [PT_W-1:0] c,
                                    logic signed [COORD_WIDTH-1:0] lo,
                                    logic signed [COORD_WIDTH-1:0] hi);
    logic signed [PT_W-1:0] lo_w;
    logic signed [PT_W-1:0] hi_w;
    lo_w = {{(PT_W - COORD_WIDTH){lo[COORD_WIDTH-1]}}, lo};
    hi_w = {{(PT_W - COORD_WIDTH){hi[COORD_WIDTH-1]}}, hi};
    return (c >= lo_w) && (c <= hi_w);
  endfunction

  logic                 adv;
  logic                 ovf;
  dv_t                  div_nxt;
  dv_t                  div_r [DIV_STEPS+1];
  logic [DIV_STEPS:0]   div_vld_r;
  ml_t                  ml_nxt;
  ml_t                  ml_r;
  logic                 ml_vld_r;
  pt_t                  pt_nxt;
  pt_t                  pt_r;
  logic                 pt_vld_r;
  tx_t                  tx_nxt;
  tx_t                  tx_r [TEX_STEPS+1];
  logic [TEX_STEPS:0]   tx_vld_r;
  res_t                 out_nxt;
  res_t                 out_r;
  logic                 out_vld_r;
  logic signed [PROD_W-1:0] shr [3];
  logic signed [PT_W-1:0]   pa;
  logic signed [PT_W-1:0]   pb;

  assign adv          = !out_vld_r || out_ch.ready;
  assign pop_ready    = adv;
  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_r;

  always_comb begin
    ovf             = ({{DIV_SHIFT{1'b0}}, pop_data.mag_num}
                      >= {pop_data.mag_den, {DIV_SHIFT{1'b0}}});
    div_nxt.org     = pop_data.org;
    div_nxt.dir     = pop_data.dir;
    div_nxt.t_lower = pop_data.t_lower;
    div_nxt.t_upper = pop_data.t_upper;
    div_nxt.neg_dn  = pop_data.neg_dn;
    div_nxt.miss    = pop_data.miss || ovf;
    div_nxt.rem     = COORD_WIDTH'(pop_data.mag_num >> DIV_SHIFT);
    div_nxt.den     = pop_data.mag_den;
    div_nxt.dvd     = {pop_data.mag_num[DIV_SHIFT-1:0], {FRAC_BITS{1'b0}}};
    div_nxt.quo     = '0;
  end

  always_comb begin
    ml_nxt.org    = div_r[DIV_STEPS].org;
    ml_nxt.t      = div_r[DIV_STEPS].quo;
    ml_nxt.neg_dn = div_r[DIV_STEPS].neg_dn;
    ml_nxt.miss   = div_r[DIV_STEPS].miss
                 || (div_r[DIV_STEPS].quo < div_r[DIV_STEPS].t_lower)
                 || (div_r[DIV_STEPS].quo > div_r[DIV_STEPS].t_upper);
    for (int k = 0; k < 3; k++) begin
      ml_nxt.prod[k] = PROD_W'($signed(div_r[DIV_STEPS].dir[k])
                              * $signed({1'b0, div_r[DIV_STEPS].quo}));
    end
  end

  always_comb begin
    pt_nxt.t      = ml_r.t;
    pt_nxt.neg_dn = ml_r.neg_dn;
    pt_nxt.miss   = ml_r.miss;
    for (int k = 0; k < 3; k++) begin
      shr[k]       = $signed(ml_r.prod[k]) >>> FRAC_BITS;
      pt_nxt.pt[k] = {{(PT_W - COORD_WIDTH){ml_r.org[k][COORD_WIDTH-1]}}, ml_r.org[k]}
                   + shr[k][PT_W-1:0];
    end
  end

  always_comb begin
    pa = pt_r.pt[0];
    pb = pt_r.pt[1];
    case (cfg.plane_axis)
      AXIS_XY: begin
        pa = pt_r.pt[0];
        pb = pt_r.pt[1];
      end
      AXIS_XZ: begin
        pa = pt_r.pt[0];
        pb = pt_r.pt[2];
      end
      AXIS_YZ: begin
        pa = pt_r.pt[1];
        pb = pt_r.pt[2];
      end
      default: begin
      end
    endcase
    tx_nxt.t          = pt_r.t;
    tx_nxt.neg_dn     = pt_r.neg_dn;
    tx_nxt.unused_pad = '0;
    tx_nxt.miss       = pt_r.miss || !in_range(pa, cfg.a_low, cfg.a_high)
                     || !in_range(pb, cfg.b_low, cfg.b_high);
    for (int k = 0; k < 3; k++) begin
      tx_nxt.pt[k] = sat_coord(pt_r.pt[k]);
    end
    tx_nxt.lane_a = tex_init(pa, cfg.a_low, cfg.a_high);
    tx_nxt.lane_b = tex_init(pb, cfg.b_low, cfg.b_high);
  end

  always_comb begin
    out_nxt = '0;
    if (!tx_r[TEX_STEPS].miss) begin
      out_nxt.hit          = 1'b1;
      out_nxt.hit_t        = tx_r[TEX_STEPS].t;
      out_nxt.point_x      = tx_r[TEX_STEPS].pt[0];
      out_nxt.point_y      = tx_r[TEX_STEPS].pt[1];
      out_nxt.point_z      = tx_r[TEX_STEPS].pt[2];
      out_nxt.front_face   = tx_r[TEX_STEPS].neg_dn;
      out_nxt.tex_u        = tx_r[TEX_STEPS].lane_a.zspan ? '0 : tx_r[TEX_STEPS].lane_a.quo;
      out_nxt.tex_v        = tx_r[TEX_STEPS].lane_b.zspan ? '0 : tx_r[TEX_STEPS].lane_b.quo;
      out_nxt.hit_material = cfg.material_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_vld_r <= '0;
      ml_vld_r  <= 1'b0;
      pt_vld_r  <= 1'b0;
      tx_vld_r  <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      div_vld_r <= {div_vld_r[DIV_STEPS-1:0], pop_valid};
      ml_vld_r  <= div_vld_r[DIV_STEPS];
      pt_vld_r  <= ml_vld_r;
      tx_vld_r  <= {tx_vld_r[TEX_STEPS-1:0], pt_vld_r};
      out_vld_r <= tx_vld_r[TEX_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div_r[0] <= div_nxt;
      for (int k = 0; k < DIV_STEPS; k++) begin
        div_r[k+1] <= div_step(div_r[k]);
      end
      ml_r     <= ml_nxt;
      pt_r     <= pt_nxt;
      tx_r[0]  <= tx_nxt;
      for (int k = 0; k < TEX_STEPS; k++) begin
        tx_r[k+1] <= tx_step(tx_r[k]);
      end
      out_r    <= out_nxt;
    end
  end

endmodule

@@ rtl/core/ray_axis_aligned_rect_hit_core.sv @@
// ----------------------------------------------------------------------------
// ray_axis_aligned_rect_hit_core
// Ray versus axis-aligned rectangle hit test in signed Q16.16.
//
// cfg_ch writes the rectangle registers (plane axis, plane offset, bounds,
// material) by index; it is always ready, and the user must write it only
// while the core idles; the block itself does not enforce this.
// in_ch carries one ray per transfer, out_ch one result per ray, in order.
// A ray passes from in_ch to out_ch through the queue, 31 stages of the
// distance divider (one quotient bit each), multiply, hit point, bounds
// check, 17 stages of the texture divider and the output register.
// One ray per cycle is sustained while out_ch is ready.
// When out_ch stalls the back pipeline holds; the four-entry queue keeps
// taking rays until it fills, then in_ch.ready drops.
// Reset clears the queue, all valid bits and the registers to their defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ray_axis_aligned_rect_hit_core (
  input logic         clk,
  input logic         rst_n,
  rarh_chan_if.sink   cfg_ch,
  rarh_chan_if.sink   in_ch,
  rarh_chan_if.source out_ch
);
  import rarh_pkg::*;

  cfg_t cfg;
  logic push_valid;
  logic push_ready;
  job_t push_data;
  logic pop_valid;
  logic pop_ready;
  job_t pop_data;

  rarh_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  rarh_front u_front (
    .in_ch      (in_ch),
    .cfg        (cfg),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  rarh_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  rarh_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.data.hit |->
      out_ch.data.hit_t == '0 && out_ch.data.point_x == '0 &&
      out_ch.data.point_y == '0 && out_ch.data.point_z == '0 &&
      !out_ch.data.front_face && out_ch.data.tex_u == '0 &&
      out_ch.data.tex_v == '0 && out_ch.data.hit_material == '0)
    else $error("miss result carries non-zero fields");

  a_tex_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.hit |->
      out_ch.data.tex_u <= (TEX_WIDTH)'(1 << TEX_BITS) &&
      out_ch.data.tex_v <= (TEX_WIDTH)'(1 << TEX_BITS))
    else $error("texture coordinate above one");

  a_material: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.hit |-> out_ch.data.hit_material == cfg.material_id)
    else $error("hit material differs from configured tag");

  a_queue_push: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && !in_ch.ready |-> pop_valid)
    else $error("input stalled while queue is empty");

endmodule
